[hw/rtl/prq_pkg.sv]
// shared constants, codes and beat structs for the priority ready-queue scheduler
// no dependencies; used by every module of the block
package prq_pkg;

   localparam int LEVELS      = 4;
   localparam int FIFO_DEPTH  = 16;
   localparam int NQUEUES     = 2 * LEVELS;
   localparam int STORE_DEPTH = NQUEUES * FIFO_DEPTH;

   localparam int LVL_W    = $clog2(LEVELS);
   localparam int Q_W      = $clog2(NQUEUES);
   localparam int HEAD_W   = $clog2(FIFO_DEPTH);
   localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int TOT_W    = $clog2(LEVELS * FIFO_DEPTH + 1);
   localparam int ADDR_W   = $clog2(STORE_DEPTH);
   localparam int ID_W     = 8;
   localparam int SPRIO_W  = 3;
   localparam int DPRIO_W  = 2;
   localparam int RAW_W    = SPRIO_W + 1;
   localparam int REQ_W    = 16;
   localparam int RSP_W    = 16;

   typedef enum logic {
      CMD_ADD  = 1'b0,
      CMD_PICK = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type              command;
      logic [ID_W-1:0]      task_id;
      logic [SPRIO_W-1:0]   static_prio;
      logic [DPRIO_W-1:0]   cur_level;
      logic                 was_preempted;
   } item_type;

   typedef struct packed {
      logic                 we;
      logic                 re;
      logic [ADDR_W-1:0]    addr;
      logic [ID_W-1:0]      wdata;
   } ram_req_type;

   typedef struct packed {
      logic                 picked_valid;
      logic [DPRIO_W-1:0]   new_level;
      logic                 banks_swapped;
      status_type           status;
   } result_type;

endpackage

[hw/rtl/priority_ready_queue_scheduler_core.sv]
// priority ready-queue scheduler, top level: handshake, sequencing, result register
// depends on prq_pkg, prq_task_ram, prq_queue_ctrl
// an accepted request beat moves the block to S_DONE; from there the result beat is registered once the output is free
// a new command is taken only after the previous one leaves S_DONE, which covers the registered task store read
// a request is taken while an earlier result still waits on rsp_tready
// reset clears queue pointers, counts, bank select and totals at once; the task store
// is not cleared, and no entry is read before it is written
module priority_ready_queue_scheduler_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // task_id[7:0], static_prio[10:8], cur_level[12:11], was_preempted[13], zero[15:14]
   input  logic [prq_pkg::REQ_W-1:0]  req_tdata,
   // command[0]
   input  logic [0:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // picked_id[7:0], picked_valid[8], new_level[10:9], banks_swapped[11],
   // status[13:12], zero[15:14]
   output logic [prq_pkg::RSP_W-1:0]  rsp_tdata
);

   typedef enum logic {
      S_IDLE,
      S_DONE
   } state_type;

   state_type                  state_ff;
   prq_pkg::result_type        pend_ff;
   logic                       rsp_valid_ff;
   logic [prq_pkg::RSP_W-1:0]  rsp_data_ff;

   prq_pkg::item_type          item;
   prq_pkg::ram_req_type       ram_req;
   prq_pkg::result_type        result;
   logic [prq_pkg::ID_W-1:0]   rdata;
   logic                       fire;
   logic                       out_free;
   logic [prq_pkg::ID_W-1:0]   picked_id;

   assign item.command       = prq_pkg::cmd_type'(req_tuser[0]);
   assign item.task_id       = req_tdata[7:0];
   assign item.static_prio   = req_tdata[10:8];
   assign item.cur_level     = req_tdata[12:11];
   assign item.was_preempted = req_tdata[13];

   assign req_tready = (state_ff == S_IDLE);
   assign fire       = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign picked_id  = pend_ff.picked_valid ? rdata : '0;

   prq_queue_ctrl u_queue_ctrl (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (item),
      .ram_req (ram_req),
      .result  (result)
   );

   prq_task_ram u_task_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  pend_ff  <= result;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // store data holds until the next read, so waiting here is safe
               if (out_free) begin
                  rsp_data_ff  <= {2'b00, pend_ff.status, pend_ff.banks_swapped,
                                   pend_ff.new_level, pend_ff.picked_valid,
                                   picked_id};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      fire |=> !req_tready)
      else $error("request taken while a command is in flight");

   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> rsp_valid_ff)
      else $error("finished command produced no result beat");

endmodule

[hw/rtl/prq_task_ram.sv]
// task id store: one write or one read port per cycle, registered read data
// depends on prq_pkg
module prq_task_ram (
   input  logic                      clock,
   input  prq_pkg::ram_req_type      ram_req,
   output logic [prq_pkg::ID_W-1:0]  rdata
);

   logic [prq_pkg::ID_W-1:0] mem_ff [prq_pkg::STORE_DEPTH];
   logic [prq_pkg::ID_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem_ff[ram_req.addr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rdata_ff <= mem_ff[ram_req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/prq_queue_ctrl.sv]
// fifo pointers, bank select and bank totals; issues store accesses per command
// depends on prq_pkg
module prq_queue_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  prq_pkg::item_type     item,
   output prq_pkg::ram_req_type  ram_req,
   output prq_pkg::result_type   result
);

   logic [prq_pkg::HEAD_W-1:0] head_ff  [prq_pkg::NQUEUES];
   logic [prq_pkg::CNT_W-1:0]  count_ff [prq_pkg::NQUEUES];
   logic                       active_sel_ff;
   logic [prq_pkg::TOT_W-1:0]  active_total_ff;
   logic [prq_pkg::TOT_W-1:0]  expired_total_ff;

   function automatic logic [prq_pkg::LVL_W-1:0] clamp_level(
      input logic [prq_pkg::RAW_W-1:0] raw);
      if (raw > prq_pkg::RAW_W'(prq_pkg::LEVELS - 1)) begin
         return prq_pkg::LVL_W'(prq_pkg::LEVELS - 1);
      end
      return prq_pkg::LVL_W'(raw);
   endfunction

   function automatic logic [prq_pkg::Q_W-1:0] Q_W_sum(input logic [prq_pkg::LVL_W-1:0] lvl);
      return prq_pkg::Q_W'(prq_pkg::LEVELS) + prq_pkg::Q_W'(lvl);
   endfunction

   // add path
   logic                       to_expired;
   logic [prq_pkg::LVL_W-1:0]  add_lvl;
   logic                       add_bank;
   logic [prq_pkg::Q_W-1:0]    add_q;

   // pick path
   logic                       swap;
   logic                       pick_bank;
   logic                       found;
   logic [prq_pkg::LVL_W-1:0]  pick_lvl;
   logic [prq_pkg::Q_W-1:0]    pick_q;

   logic                       is_pick;
   logic [prq_pkg::Q_W-1:0]    q_sel;
   logic [prq_pkg::HEAD_W-1:0] q_head;
   logic [prq_pkg::CNT_W-1:0]  q_count;
   logic                       q_full;
   logic [prq_pkg::SUM_W-1:0]  slot_sum;
   logic [prq_pkg::HEAD_W-1:0] slot;
   logic [prq_pkg::HEAD_W:0]   head_inc;
   logic [prq_pkg::HEAD_W-1:0] head_next;
   logic [prq_pkg::ADDR_W-1:0] q_base;

   always_comb begin
      to_expired = item.was_preempted && (item.cur_level == '0);
      priority if (to_expired) begin
         add_lvl = (item.static_prio == '0) ? '0
                   : clamp_level(prq_pkg::RAW_W'(item.static_prio) - prq_pkg::RAW_W'(1));
      end else if (item.was_preempted) begin
         add_lvl = clamp_level(prq_pkg::RAW_W'(item.cur_level) - prq_pkg::RAW_W'(1));
      end else begin
         add_lvl = clamp_level(prq_pkg::RAW_W'(item.cur_level));
      end
      add_bank = to_expired ? ~active_sel_ff : active_sel_ff;
      add_q    = add_bank ? Q_W_sum(add_lvl) : prq_pkg::Q_W'(add_lvl);
   end

   // highest non-empty level of the bank that will be active
   always_comb begin
      swap      = (active_total_ff == '0);
      pick_bank = swap ? ~active_sel_ff : active_sel_ff;
      found     = 1'b0;
      pick_lvl  = '0;
      for (int l = 0; l < prq_pkg::LEVELS; l++) begin
         if ((pick_bank ? count_ff[prq_pkg::LEVELS + l] : count_ff[l]) != '0) begin
            found    = 1'b1;
            pick_lvl = prq_pkg::LVL_W'(l);
         end
      end
      pick_q = pick_bank ? Q_W_sum(pick_lvl) : prq_pkg::Q_W'(pick_lvl);
   end

   always_comb begin
      is_pick  = (item.command == prq_pkg::CMD_PICK);
      q_sel    = is_pick ? pick_q : add_q;
      q_head   = head_ff[q_sel];
      q_count  = count_ff[q_sel];
      q_full   = (q_count == prq_pkg::CNT_W'(prq_pkg::FIFO_DEPTH));
      slot_sum = prq_pkg::SUM_W'(q_head) + prq_pkg::SUM_W'(q_count);
      if (slot_sum >= prq_pkg::SUM_W'(prq_pkg::FIFO_DEPTH)) begin
         slot = prq_pkg::HEAD_W'(slot_sum - prq_pkg::SUM_W'(prq_pkg::FIFO_DEPTH));
      end else begin
         slot = prq_pkg::HEAD_W'(slot_sum);
      end
      head_inc  = (prq_pkg::HEAD_W + 1)'(q_head) + (prq_pkg::HEAD_W + 1)'(1);
      head_next = (head_inc == (prq_pkg::HEAD_W + 1)'(prq_pkg::FIFO_DEPTH)) ? '0
                  : prq_pkg::HEAD_W'(head_inc);
      q_base    = prq_pkg::ADDR_W'(q_sel) * prq_pkg::ADDR_W'(prq_pkg::FIFO_DEPTH);

      ram_req.we    = fire && !is_pick && !q_full;
      ram_req.re    = fire && is_pick && found;
      ram_req.addr  = q_base + prq_pkg::ADDR_W'(is_pick ? q_head : slot);
      ram_req.wdata = item.task_id;

      result.picked_valid  = is_pick && found;
      result.new_level     = is_pick ? '0 : prq_pkg::DPRIO_W'(add_lvl);
      result.banks_swapped = is_pick && swap;
      if (is_pick) begin
         result.status = found ? prq_pkg::ST_OK : prq_pkg::ST_EMPTY;
      end else begin
         result.status = q_full ? prq_pkg::ST_FULL : prq_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < prq_pkg::NQUEUES; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         active_sel_ff    <= 1'b0;
         active_total_ff  <= '0;
         expired_total_ff <= '0;
      end else if (fire) begin
         if (is_pick) begin
            if (swap) begin
               active_sel_ff    <= ~active_sel_ff;
               expired_total_ff <= '0;
            end
            if (found) begin
               head_ff[q_sel]  <= head_next;
               count_ff[q_sel] <= q_count - prq_pkg::CNT_W'(1);
               active_total_ff <= (swap ? expired_total_ff : active_total_ff)
                                  - prq_pkg::TOT_W'(1);
            end else if (swap) begin
               active_total_ff <= expired_total_ff;
            end
         end else if (!q_full) begin
            count_ff[q_sel] <= q_count + prq_pkg::CNT_W'(1);
            if (to_expired) begin
               expired_total_ff <= expired_total_ff + prq_pkg::TOT_W'(1);
            end else begin
               active_total_ff <= active_total_ff + prq_pkg::TOT_W'(1);
            end
         end
      end
   end

   a_pick_empty_swaps: assert property (@(posedge clock) disable iff (reset)
      (fire && is_pick && swap) |=> (active_sel_ff != $past(active_sel_ff)))
      else $error("pick on empty active bank did not swap banks");

   a_full_add_no_change: assert property (@(posedge clock) disable iff (reset)
      (fire && !is_pick && q_full) |=> ($stable(active_total_ff) && $stable(expired_total_ff)))
      else $error("dropped add changed bank totals");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      (active_total_ff <= prq_pkg::TOT_W'(prq_pkg::LEVELS * prq_pkg::FIFO_DEPTH)))
      else $error("active total exceeds bank capacity");

   a_one_port_op: assert property (@(posedge clock) disable iff (reset)
      !(ram_req.we && ram_req.re))
      else $error("store read and write issued together");

endmodule
